[hw/rtl/nmea_gga_zda_sentence_catcher_top_defines.svh]
// Assertion macros shared by the sentence catcher RTL.
`ifndef NMEA_GGA_ZDA_SENTENCE_CATCHER_TOP_DEFINES_SVH
`define NMEA_GGA_ZDA_SENTENCE_CATCHER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NGZ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NGZ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ngz_pkg.sv]
// Package with constants, types and helpers for the NMEA sentence catcher.
package ngz_pkg;

  // Capture limits: the highest store position, header included.
  localparam int GGA_LIMIT = 130;
  localparam int ZDA_LIMIT = 100;

  // Widths derived from the limits.
  localparam int GGA_CNT_W  = $clog2(GGA_LIMIT + 2);
  localparam int ZDA_CNT_W  = $clog2(ZDA_LIMIT + 2);
  localparam int GGA_ADDR_W = $clog2(GGA_LIMIT + 1);
  localparam int ZDA_ADDR_W = $clog2(ZDA_LIMIT + 1);

  // Header length in bytes.
  localparam int HDR_LEN = 6;

  // Characters of interest.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_Z      = 8'h5A;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_RX     = 2'd0,
    ACT_RD_GGA = 2'd1,
    ACT_RD_ZDA = 2'd2,
    ACT_ACK    = 2'd3
  } action_t;

  // Header matcher and capture states.
  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_DOLLAR  = 4'd1,
    ST_G       = 4'd2,
    ST_TALK    = 4'd3,
    ST_GG1     = 4'd4,
    ST_GG2     = 4'd5,
    ST_Z       = 4'd6,
    ST_ZD      = 4'd7,
    ST_GGA_CAP = 4'd8,
    ST_ZDA_CAP = 4'd9
  } match_state_t;

  // Source of the read data in the output word.
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_HDR  = 2'd1,
    SRC_GGA  = 2'd2,
    SRC_ZDA  = 2'd3
  } rd_src_t;

  // Byte of a stored header at positions 0 to 5.
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic gn,
                                          input logic is_gga);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CH_DOLLAR;
      3'd1:    b = CH_G;
      3'd2:    b = gn ? CH_N : CH_P;
      3'd3:    b = is_gga ? CH_G : CH_Z;
      3'd4:    b = is_gga ? CH_G : CH_D;
      3'd5:    b = CH_A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/nmea_gga_zda_sentence_catcher_top.sv]
// Top level of the NMEA GGA/ZDA sentence catcher.
//
// Input channel (in_valid/in_ready) carries one word per item: an action, a
// received character, a read position and the working flag. Action 0 feeds a
// character to the header matcher; actions 1 and 2 read a byte of the GGA or
// ZDA store; action 3 clears both ready flags. A low working flag returns the
// matcher to idle and clears the flags first.
// Output channel (out_valid/out_ready) returns exactly one word per item: the
// read byte (zero when out of range or not a read) and the status after the
// item: ready flags, captured lengths and the last talker.
// out_valid rises in the cycle after acceptance, when the registered read port
// of the sentence memories delivers its byte. One item is taken every cycle while
// the output is free or is being taken in the same cycle.
// When the receiver stalls, the output word holds and in_ready drops until
// it is taken. Reset clears the matcher, counts, flags and output valid; the
// memory contents are not cleared, since only written positions are read.
`include "nmea_gga_zda_sentence_catcher_top_defines.svh"

module nmea_gga_zda_sentence_catcher_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] rx_byte,
  input  logic [7:0] read_index,
  input  logic       work_enable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       gga_ready,
  output logic       zda_ready,
  output logic [7:0] gga_length,
  output logic [6:0] zda_length,
  output logic       talker_is_gn
);

  // Sentence memories; positions below the header length stay unused.
  logic [7:0] gga_mem [ngz_pkg::GGA_LIMIT + 1];
  logic [7:0] zda_mem [ngz_pkg::ZDA_LIMIT + 1];
  logic [7:0] gga_rdata;
  logic [7:0] zda_rdata;

  // Matcher and status registers.
  ngz_pkg::match_state_t         state, state_next;
  logic                          talker_gn, talker_gn_next;
  logic                          gga_hdr_gn, gga_hdr_gn_next;
  logic                          zda_hdr_gn, zda_hdr_gn_next;
  logic [ngz_pkg::GGA_CNT_W-1:0] gga_count, gga_count_next;
  logic [ngz_pkg::ZDA_CNT_W-1:0] zda_count, zda_count_next;
  logic                          gga_flag, gga_flag_next;
  logic                          zda_flag, zda_flag_next;
  logic [7:0]                    prev_byte, prev_byte_next;

  // Output stage.
  ngz_pkg::rd_src_t rd_src, rd_src_next;
  logic [7:0]       hdr_data, hdr_data_next;

  logic             accept;
  ngz_pkg::action_t act;
  logic             gga_we, zda_we, gga_re, zda_re;
  logic             crlf;
  logic             gga_in_range, zda_in_range;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign act      = ngz_pkg::action_t'(action);
  assign crlf     = (rx_byte == ngz_pkg::CH_LF) && (prev_byte == ngz_pkg::CH_CR);

  // Read position checks against the captured length and the store size.
  assign gga_in_range = (10'(read_index) < 10'(gga_count)) &&
                        (10'(read_index) <= 10'(ngz_pkg::GGA_LIMIT));
  assign zda_in_range = (10'(read_index) < 10'(zda_count)) &&
                        (10'(read_index) <= 10'(ngz_pkg::ZDA_LIMIT));

  // Next state, store writes and read selection for the accepted word.
  always_comb begin
    state_next      = state;
    talker_gn_next  = talker_gn;
    gga_hdr_gn_next = gga_hdr_gn;
    zda_hdr_gn_next = zda_hdr_gn;
    gga_count_next  = gga_count;
    zda_count_next  = zda_count;
    gga_flag_next   = gga_flag;
    zda_flag_next   = zda_flag;
    prev_byte_next  = prev_byte;
    rd_src_next     = rd_src;
    hdr_data_next   = hdr_data;
    gga_we          = 1'b0;
    zda_we          = 1'b0;
    gga_re          = 1'b0;
    zda_re          = 1'b0;
    if (accept) begin
      rd_src_next = ngz_pkg::SRC_ZERO;
      if (!work_enable) begin
        state_next    = ngz_pkg::ST_IDLE;
        gga_flag_next = 1'b0;
        zda_flag_next = 1'b0;
      end
      unique case (act)
        ngz_pkg::ACT_RX: begin
          if (work_enable) begin
            prev_byte_next = rx_byte;
            unique case (state)
              ngz_pkg::ST_DOLLAR: begin
                if (rx_byte == ngz_pkg::CH_G) begin
                  state_next = ngz_pkg::ST_G;
                end else begin
                  state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                               : ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_G: begin
                if (rx_byte == ngz_pkg::CH_P) begin
                  talker_gn_next = 1'b0;
                  state_next     = ngz_pkg::ST_TALK;
                end else if (rx_byte == ngz_pkg::CH_N) begin
                  talker_gn_next = 1'b1;
                  state_next     = ngz_pkg::ST_TALK;
                end else begin
                  state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                               : ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_TALK: begin
                if (rx_byte == ngz_pkg::CH_G) begin
                  state_next = ngz_pkg::ST_GG1;
                end else if (rx_byte == ngz_pkg::CH_Z) begin
                  state_next = ngz_pkg::ST_Z;
                end else begin
                  state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                               : ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_GG1: begin
                if (rx_byte == ngz_pkg::CH_G) begin
                  state_next = ngz_pkg::ST_GG2;
                end else begin
                  state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                               : ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_GG2: begin
                if (rx_byte == ngz_pkg::CH_A) begin
                  // The header bytes are implied; only the talker is kept.
                  gga_flag_next   = 1'b0;
                  gga_hdr_gn_next = talker_gn;
                  gga_count_next  = ngz_pkg::GGA_CNT_W'(ngz_pkg::HDR_LEN);
                  state_next      = ngz_pkg::ST_GGA_CAP;
                end else begin
                  state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                               : ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_Z: begin
                if (rx_byte == ngz_pkg::CH_D) begin
                  state_next = ngz_pkg::ST_ZD;
                end else begin
                  state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                               : ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_ZD: begin
                if (rx_byte == ngz_pkg::CH_A) begin
                  zda_flag_next   = 1'b0;
                  zda_hdr_gn_next = talker_gn;
                  zda_count_next  = ngz_pkg::ZDA_CNT_W'(ngz_pkg::HDR_LEN);
                  state_next      = ngz_pkg::ST_ZDA_CAP;
                end else begin
                  state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                               : ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_GGA_CAP: begin
                gga_we         = (10'(gga_count) <= 10'(ngz_pkg::GGA_LIMIT));
                gga_count_next = gga_count + 1'b1;
                if (crlf) begin
                  state_next    = ngz_pkg::ST_IDLE;
                  gga_flag_next = 1'b1;
                end
                if (10'(gga_count_next) > 10'(ngz_pkg::GGA_LIMIT)) begin
                  state_next = ngz_pkg::ST_IDLE;
                end
              end
              ngz_pkg::ST_ZDA_CAP: begin
                zda_we         = (10'(zda_count) <= 10'(ngz_pkg::ZDA_LIMIT));
                zda_count_next = zda_count + 1'b1;
                if (crlf) begin
                  state_next    = ngz_pkg::ST_IDLE;
                  zda_flag_next = 1'b1;
                end
                if (10'(zda_count_next) > 10'(ngz_pkg::ZDA_LIMIT)) begin
                  state_next = ngz_pkg::ST_IDLE;
                end
              end
              default: begin
                // Idle, and any code outside the list, looks for a '$'.
                state_next = (rx_byte == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR
                                                             : ngz_pkg::ST_IDLE;
              end
            endcase
          end
        end
        ngz_pkg::ACT_RD_GGA: begin
          if (gga_in_range) begin
            if (10'(read_index) < 10'(ngz_pkg::HDR_LEN)) begin
              rd_src_next   = ngz_pkg::SRC_HDR;
              hdr_data_next = ngz_pkg::hdr_byte(read_index[2:0], gga_hdr_gn, 1'b1);
            end else begin
              rd_src_next = ngz_pkg::SRC_GGA;
              gga_re      = 1'b1;
            end
          end
        end
        ngz_pkg::ACT_RD_ZDA: begin
          if (zda_in_range) begin
            if (10'(read_index) < 10'(ngz_pkg::HDR_LEN)) begin
              rd_src_next   = ngz_pkg::SRC_HDR;
              hdr_data_next = ngz_pkg::hdr_byte(read_index[2:0], zda_hdr_gn, 1'b0);
            end else begin
              rd_src_next = ngz_pkg::SRC_ZDA;
              zda_re      = 1'b1;
            end
          end
        end
        ngz_pkg::ACT_ACK: begin
          gga_flag_next = 1'b0;
          zda_flag_next = 1'b0;
        end
        default: begin
          gga_flag_next = 1'b0;
          zda_flag_next = 1'b0;
        end
      endcase
    end
  end

  // GGA memory: one write port at the capture position, one registered read.
  always_ff @(posedge clk) begin
    if (gga_we) begin
      gga_mem[gga_count[ngz_pkg::GGA_ADDR_W-1:0]] <= rx_byte;
    end
    if (gga_re) begin
      gga_rdata <= gga_mem[read_index[ngz_pkg::GGA_ADDR_W-1:0]];
    end
  end

  // ZDA memory: one write port at the capture position, one registered read.
  always_ff @(posedge clk) begin
    if (zda_we) begin
      zda_mem[zda_count[ngz_pkg::ZDA_ADDR_W-1:0]] <= rx_byte;
    end
    if (zda_re) begin
      zda_rdata <= zda_mem[read_index[ngz_pkg::ZDA_ADDR_W-1:0]];
    end
  end

  // Control and status registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ngz_pkg::ST_IDLE;
      talker_gn  <= 1'b0;
      gga_hdr_gn <= 1'b0;
      zda_hdr_gn <= 1'b0;
      gga_count  <= '0;
      zda_count  <= '0;
      gga_flag   <= 1'b0;
      zda_flag   <= 1'b0;
      prev_byte  <= 8'h00;
      out_valid  <= 1'b0;
      rd_src     <= ngz_pkg::SRC_ZERO;
    end else begin
      state      <= state_next;
      talker_gn  <= talker_gn_next;
      gga_hdr_gn <= gga_hdr_gn_next;
      zda_hdr_gn <= zda_hdr_gn_next;
      gga_count  <= gga_count_next;
      zda_count  <= zda_count_next;
      gga_flag   <= gga_flag_next;
      zda_flag   <= zda_flag_next;
      prev_byte  <= prev_byte_next;
      rd_src     <= rd_src_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Header byte held for the output word.
  always_ff @(posedge clk) begin
    hdr_data <= hdr_data_next;
  end

  // Output word; the status registers always reflect the word on display.
  always_comb begin
    unique case (rd_src)
      ngz_pkg::SRC_HDR: read_data = hdr_data;
      ngz_pkg::SRC_GGA: read_data = gga_rdata;
      ngz_pkg::SRC_ZDA: read_data = zda_rdata;
      default:          read_data = 8'h00;
    endcase
  end

  assign gga_ready    = gga_flag;
  assign zda_ready    = zda_flag;
  assign gga_length   = 8'(gga_count);
  assign zda_length   = 7'(zda_count);
  assign talker_is_gn = talker_gn;

  // Checks on the capture bounds and on the disable and acknowledge paths.
  `NGZ_ASSERT_NOW(a_gga_count_bound, clk, rst, 1'b1,
                  10'(gga_count) <= 10'(ngz_pkg::GGA_LIMIT + 1),
                  "GGA count passed its limit")
  `NGZ_ASSERT_NOW(a_gga_cap_window, clk, rst, state == ngz_pkg::ST_GGA_CAP,
                  (10'(gga_count) >= 10'(ngz_pkg::HDR_LEN)) &&
                  (10'(gga_count) <= 10'(ngz_pkg::GGA_LIMIT)),
                  "GGA capture with count outside the store")
  `NGZ_ASSERT_NEXT(a_disable_idle, clk, rst, accept && !work_enable,
                   (state == ngz_pkg::ST_IDLE) && !gga_flag && !zda_flag,
                   "Disabled word left matcher busy or a flag set")
  `NGZ_ASSERT_NEXT(a_ack_clears, clk, rst, accept && (act == ngz_pkg::ACT_ACK),
                   !gga_flag && !zda_flag && out_valid,
                   "Acknowledge did not clear the ready flags")

endmodule

[tb/sv/nmea_gga_zda_sentence_catcher_top_tb.sv]
// Self-checking testbench for the NMEA GGA/ZDA sentence catcher top level.
`timescale 1ns / 100ps

module nmea_gga_zda_sentence_catcher_top_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_CYCLES = 400;

  // Status word returned for every item.
  typedef struct packed {
    logic [7:0] data;
    logic       gga_rdy;
    logic       zda_rdy;
    logic [7:0] gga_len;
    logic [6:0] zda_len;
    logic       gn;
  } catch_status_t;

  // One row of the directed stimulus.
  typedef struct {
    ngz_pkg::action_t act;
    logic [7:0]       ch;
    logic [7:0]       idx;
    logic             en;
    logic             typed;
    catch_status_t    want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  ngz_pkg::action_t action;
  logic [7:0]       rx_byte;
  logic [7:0]       read_index;
  logic             work_enable;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       read_data;
  logic             gga_ready;
  logic             zda_ready;
  logic [7:0]       gga_length;
  logic [6:0]       zda_length;
  logic             talker_is_gn;

  // Typed expectation that travels with the current input word.
  logic          row_typed;
  catch_status_t row_want;

  catch_status_t pending_status[$];
  stim_row_t     dir_rows[$];
  int            mismatch_cnt = 0;
  int            words_sent = 0;
  int            cycle_cnt = 0;
  logic          tx_steady = 1'b0;
  logic          held = 1'b0;

  // Shadow copy of the catcher state.
  ngz_pkg::match_state_t mstate;
  logic                  talker_n;
  logic [7:0]            gga_mem [0:ngz_pkg::GGA_LIMIT];
  logic [7:0]            zda_mem [0:ngz_pkg::ZDA_LIMIT];
  int                    gga_cnt;
  int                    zda_cnt;
  logic                  gga_done;
  logic                  zda_done;
  logic [7:0]            last_char;

  nmea_gga_zda_sentence_catcher_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .rx_byte      (rx_byte),
    .read_index   (read_index),
    .work_enable  (work_enable),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .gga_ready    (gga_ready),
    .zda_ready    (zda_ready),
    .gga_length   (gga_length),
    .zda_length   (zda_length),
    .talker_is_gn (talker_is_gn)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // A mismatch in the header leaves the matcher idle unless it is a new '$'.
  function automatic ngz_pkg::match_state_t after_miss(input logic [7:0] c);
    return (c == ngz_pkg::CH_DOLLAR) ? ngz_pkg::ST_DOLLAR : ngz_pkg::ST_IDLE;
  endfunction

  // Advance the header matcher or the capture by one received character.
  function automatic void take_char(input logic [7:0] c);
    logic [7:0] prior;
    prior = last_char;
    last_char = c;
    case (mstate)
      ngz_pkg::ST_DOLLAR: mstate = (c == ngz_pkg::CH_G) ? ngz_pkg::ST_G : after_miss(c);
      ngz_pkg::ST_G: begin
        if (c == ngz_pkg::CH_P) begin
          talker_n = 1'b0;
          mstate = ngz_pkg::ST_TALK;
        end else if (c == ngz_pkg::CH_N) begin
          talker_n = 1'b1;
          mstate = ngz_pkg::ST_TALK;
        end else begin
          mstate = after_miss(c);
        end
      end
      ngz_pkg::ST_TALK: begin
        if (c == ngz_pkg::CH_G) mstate = ngz_pkg::ST_GG1;
        else if (c == ngz_pkg::CH_Z) mstate = ngz_pkg::ST_Z;
        else mstate = after_miss(c);
      end
      ngz_pkg::ST_GG1: mstate = (c == ngz_pkg::CH_G) ? ngz_pkg::ST_GG2 : after_miss(c);
      ngz_pkg::ST_Z: mstate = (c == ngz_pkg::CH_D) ? ngz_pkg::ST_ZD : after_miss(c);
      ngz_pkg::ST_GG2: begin
        if (c == ngz_pkg::CH_A) begin
          gga_done = 1'b0;
          gga_mem[0] = ngz_pkg::CH_DOLLAR;
          gga_mem[1] = ngz_pkg::CH_G;
          gga_mem[2] = talker_n ? ngz_pkg::CH_N : ngz_pkg::CH_P;
          gga_mem[3] = ngz_pkg::CH_G;
          gga_mem[4] = ngz_pkg::CH_G;
          gga_mem[5] = ngz_pkg::CH_A;
          gga_cnt = ngz_pkg::HDR_LEN;
          mstate = ngz_pkg::ST_GGA_CAP;
        end else begin
          mstate = after_miss(c);
        end
      end
      ngz_pkg::ST_ZD: begin
        if (c == ngz_pkg::CH_A) begin
          zda_done = 1'b0;
          zda_mem[0] = ngz_pkg::CH_DOLLAR;
          zda_mem[1] = ngz_pkg::CH_G;
          zda_mem[2] = talker_n ? ngz_pkg::CH_N : ngz_pkg::CH_P;
          zda_mem[3] = ngz_pkg::CH_Z;
          zda_mem[4] = ngz_pkg::CH_D;
          zda_mem[5] = ngz_pkg::CH_A;
          zda_cnt = ngz_pkg::HDR_LEN;
          mstate = ngz_pkg::ST_ZDA_CAP;
        end else begin
          mstate = after_miss(c);
        end
      end
      ngz_pkg::ST_GGA_CAP: begin
        if (gga_cnt <= ngz_pkg::GGA_LIMIT) gga_mem[gga_cnt] = c;
        gga_cnt++;
        if (c == ngz_pkg::CH_LF && prior == ngz_pkg::CH_CR) begin
          mstate = ngz_pkg::ST_IDLE;
          gga_done = 1'b1;
        end
        if (gga_cnt > ngz_pkg::GGA_LIMIT) mstate = ngz_pkg::ST_IDLE;
      end
      ngz_pkg::ST_ZDA_CAP: begin
        if (zda_cnt <= ngz_pkg::ZDA_LIMIT) zda_mem[zda_cnt] = c;
        zda_cnt++;
        if (c == ngz_pkg::CH_LF && prior == ngz_pkg::CH_CR) begin
          mstate = ngz_pkg::ST_IDLE;
          zda_done = 1'b1;
        end
        if (zda_cnt > ngz_pkg::ZDA_LIMIT) mstate = ngz_pkg::ST_IDLE;
      end
      default: mstate = after_miss(c);
    endcase
  endfunction

  // Apply one item to the shadow state and return the status word it yields.
  function automatic catch_status_t predict_status(input ngz_pkg::action_t act,
                                                   input logic [7:0] c,
                                                   input logic [7:0] idx, input logic en);
    catch_status_t s;
    s = '0;
    if (!en) begin
      mstate = ngz_pkg::ST_IDLE;
      gga_done = 1'b0;
      zda_done = 1'b0;
    end
    case (act)
      ngz_pkg::ACT_RX: if (en) take_char(c);
      ngz_pkg::ACT_RD_GGA: begin
        if (idx < gga_cnt && idx <= ngz_pkg::GGA_LIMIT) s.data = gga_mem[idx];
      end
      ngz_pkg::ACT_RD_ZDA: begin
        if (idx < zda_cnt && idx <= ngz_pkg::ZDA_LIMIT) s.data = zda_mem[idx];
      end
      default: begin
        gga_done = 1'b0;
        zda_done = 1'b0;
      end
    endcase
    s.gga_rdy = gga_done;
    s.zda_rdy = zda_done;
    s.gga_len = gga_cnt[7:0];
    s.zda_len = zda_cnt[6:0];
    s.gn = talker_n;
    return s;
  endfunction

  function automatic catch_status_t status_of(input logic [7:0] d, input logic gr,
                                              input logic zr, input logic [7:0] gl,
                                              input logic [6:0] zl, input logic gn);
    catch_status_t s;
    s.data = d;
    s.gga_rdy = gr;
    s.zda_rdy = zr;
    s.gga_len = gl;
    s.zda_len = zl;
    s.gn = gn;
    return s;
  endfunction

  task automatic add_row(input ngz_pkg::action_t act, input logic [7:0] ch,
                         input logic [7:0] idx, input logic en, input logic typed,
                         input catch_status_t want);
    stim_row_t r;
    r.act = act;
    r.ch = ch;
    r.idx = idx;
    r.en = en;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word and hold it until it is accepted.
  task automatic send_item(input ngz_pkg::action_t act, input logic [7:0] c,
                           input logic [7:0] idx, input logic en, input logic typed,
                           input catch_status_t want);
    int gap;
    gap = tx_steady ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    rx_byte <= c;
    read_index <= idx;
    work_enable <= en;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!in_ready);
    if (!(act == ngz_pkg::ACT_RX && !en)) words_sent++;
  endtask

  // A read of either store or an acknowledge, with random unused fields.
  task automatic send_query();
    int r;
    logic [7:0] idx;
    logic en;
    r = $urandom_range(0, 99);
    en = ($urandom_range(0, 99) >= 3);
    if (r < 45) begin
      idx = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, ngz_pkg::GGA_LIMIT + 4))
                                          : 8'($urandom_range(0, 255));
      send_item(ngz_pkg::ACT_RD_GGA, 8'($urandom_range(0, 255)), idx, en, 1'b0, '0);
    end else if (r < 90) begin
      idx = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, ngz_pkg::ZDA_LIMIT + 4))
                                          : 8'($urandom_range(0, 255));
      send_item(ngz_pkg::ACT_RD_ZDA, 8'($urandom_range(0, 255)), idx, en, 1'b0, '0);
    end else begin
      send_item(ngz_pkg::ACT_ACK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                en, 1'b0, '0);
    end
  endtask

  // Receive one character, sometimes after a read or acknowledge and rarely while disabled.
  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(0, 99) < 5) send_query();
    send_item(ngz_pkg::ACT_RX, c, 8'($urandom_range(0, 255)),
              ($urandom_range(0, 199) != 0), 1'b0, '0);
  endtask

  // Sentence body characters: mostly printable, with some delimiters mixed in.
  function automatic logic [7:0] body_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 80) return ngz_pkg::CH_DOLLAR;
    if (r < 85) return ngz_pkg::CH_CR;
    if (r < 88) return ngz_pkg::CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Header, body and CR LF; a cut below six breaks the header after that many bytes.
  task automatic send_sentence(input logic is_gga, input logic gn, input int cut,
                               input int body_len);
    logic [7:0] hdr [6];
    hdr[0] = ngz_pkg::CH_DOLLAR;
    hdr[1] = ngz_pkg::CH_G;
    hdr[2] = gn ? ngz_pkg::CH_N : ngz_pkg::CH_P;
    hdr[3] = is_gga ? ngz_pkg::CH_G : ngz_pkg::CH_Z;
    hdr[4] = is_gga ? ngz_pkg::CH_G : ngz_pkg::CH_D;
    hdr[5] = ngz_pkg::CH_A;
    for (int i = 0; i < cut; i++) send_char(hdr[i]);
    if (cut < ngz_pkg::HDR_LEN) begin
      send_char($urandom_range(0, 1) ? ngz_pkg::CH_DOLLAR : 8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < body_len; i++) send_char(body_char());
      send_char(ngz_pkg::CH_CR);
      send_char(ngz_pkg::CH_LF);
    end
  endtask

  // Body length: mostly short, a few that end just below, at or past the limit.
  function automatic int pick_body(input int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 92) return $urandom_range(0, 24);
    if (r < 94) return limit - 8;
    if (r < 97) return limit - 7;
    if (r < 98) return limit - 6;
    return $urandom_range(limit - 5, limit + 10);
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // Compare each returned word with the oldest expectation, then predict new words.
  always @(posedge clk) begin : score
    catch_status_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          $error("status word returned with no item outstanding");
          mismatch_cnt++;
        end else begin
          want = pending_status.pop_front();
          check_field("read_data", want.data, read_data);
          check_field("gga_ready", 8'(want.gga_rdy), 8'(gga_ready));
          check_field("zda_ready", 8'(want.zda_rdy), 8'(zda_ready));
          check_field("gga_length", want.gga_len, gga_length);
          check_field("zda_length", 8'(want.zda_len), 8'(zda_length));
          check_field("talker_is_gn", 8'(want.gn), 8'(talker_is_gn));
        end
      end
      if (in_valid && in_ready) begin
        want = predict_status(action, rx_byte, read_index, work_enable);
        if (row_typed) want = row_want;
        pending_status.push_back(want);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("nmea_gga_zda_sentence_catcher_top: mismatch");
      $finish;
    end
  end

  // Receiver: runs of ready, random stalls, and one long hold-off to back up the block.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && words_sent >= 500) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < 25) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        n = pause_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Sender: directed rows, then random sentences, queries and noise.
  initial begin : sender
    int r;
    int total;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ngz_pkg::ACT_RX;
    rx_byte = '0;
    read_index = '0;
    work_enable = 1'b1;
    row_typed = 1'b0;
    row_want = '0;
    mstate = ngz_pkg::ST_IDLE;
    talker_n = 1'b0;
    gga_cnt = 0;
    zda_cnt = 0;
    gga_done = 1'b0;
    zda_done = 1'b0;
    last_char = '0;

    // Reads and acknowledge right after reset, then a GN GGA sentence with a '$'
    // restart in its header and a '$' inside its body, reads of it, the disabled
    // case, and a GP ZDA header left half done.
    add_row(ngz_pkg::ACT_RD_GGA, 8'h00, 8'd0, 1'b1, 1'b1,
            status_of(8'd0, 1'b0, 1'b0, 8'd0, 7'd0, 1'b0));
    add_row(ngz_pkg::ACT_RD_ZDA, 8'hFF, 8'hFF, 1'b1, 1'b1,
            status_of(8'd0, 1'b0, 1'b0, 8'd0, 7'd0, 1'b0));
    add_row(ngz_pkg::ACT_ACK, 8'h00, 8'd0, 1'b1, 1'b1,
            status_of(8'd0, 1'b0, 1'b0, 8'd0, 7'd0, 1'b0));
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_DOLLAR, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_G, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_DOLLAR, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_G, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_N, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_G, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_G, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_A, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_DOLLAR, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, 8'hFF, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, 8'h00, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_CR, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_LF, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RD_GGA, 8'h00, 8'd2, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RD_GGA, 8'h00, 8'd11, 1'b1, 1'b1,
            status_of(8'd0, 1'b1, 1'b0, 8'd11, 7'd0, 1'b1));
    add_row(ngz_pkg::ACT_ACK, 8'h00, 8'd0, 1'b1, 1'b1,
            status_of(8'd0, 1'b0, 1'b0, 8'd11, 7'd0, 1'b1));
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_DOLLAR, 8'd0, 1'b0, 1'b1,
            status_of(8'd0, 1'b0, 1'b0, 8'd11, 7'd0, 1'b1));
    add_row(ngz_pkg::ACT_RD_GGA, 8'h00, 8'd0, 1'b0, 1'b1,
            status_of(ngz_pkg::CH_DOLLAR, 1'b0, 1'b0, 8'd11, 7'd0, 1'b1));
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_DOLLAR, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_G, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_P, 8'd0, 1'b1, 1'b0, '0);
    add_row(ngz_pkg::ACT_RX, ngz_pkg::CH_Z, 8'd0, 1'b1, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].ch, dir_rows[i].idx, dir_rows[i].en,
                dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: well-formed sentences dominate, with reads, noise and broken headers.
    total = words_sent + RANDOM_WORDS;
    while (words_sent < total) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if ($urandom_range(0, 1)) begin
          send_sentence(1'b1, 1'($urandom_range(0, 1)), ngz_pkg::HDR_LEN,
                        pick_body(ngz_pkg::GGA_LIMIT));
        end else begin
          send_sentence(1'b0, 1'($urandom_range(0, 1)), ngz_pkg::HDR_LEN,
                        pick_body(ngz_pkg::ZDA_LIMIT));
        end
      end else if (r < 77) begin
        repeat ($urandom_range(1, 4)) send_query();
      end else if (r < 88) begin
        repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
      end else begin
        send_sentence(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(1, 5), 0);
      end
    end

    // Drain: wait for every outstanding word, then a few more cycles.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("nmea_gga_zda_sentence_catcher_top: match");
    end else begin
      $display("nmea_gga_zda_sentence_catcher_top: mismatch");
    end
    $finish;
  end

endmodule
